// ===== sv/bct_pkg.sv =====
// shared types, event codes and helpers for the button combination tracker
`default_nettype none

package bct_pkg;

    localparam int DEF_BUTTON_COUNT = 13;

    localparam int ID_W = 4;
    localparam int EV_W = 4;

    localparam logic [EV_W-1:0] NO_RECORD   = 4'd15;
    localparam logic [EV_W-1:0] EV_DOWN     = 4'd0;
    localparam logic [EV_W-1:0] EV_CLICK    = 4'd1;
    localparam logic [EV_W-1:0] EV_DOUBLE   = 4'd2;
    localparam logic [EV_W-1:0] EV_REPEAT   = 4'd3;
    localparam logic [EV_W-1:0] EV_SHORT_UP = 4'd5;
    localparam logic [EV_W-1:0] EV_LONG_UP  = 4'd7;
    localparam logic [EV_W-1:0] EV_HOLD_UP  = 4'd9;
    localparam logic [EV_W-1:0] EV_MAX      = 4'd9;

    // record count saturates here, two is all the rules need
    localparam logic [1:0] CNT_SAT = 2'd2;

    // query token that walks down the row of cells
    typedef struct packed {
        logic            valid;
        logic [EV_W-1:0] key;
        logic [ID_W-1:0] self_id;
        logic            found;
        logic [ID_W-1:0] found_idx;
        logic [1:0]      cnt;
    } scan_t;

    // broadcast record write
    typedef struct packed {
        logic            en;
        logic [ID_W-1:0] id;
        logic [EV_W-1:0] val;
    } rec_wr_t;

    typedef struct packed {
        logic            is_combination;
        logic [ID_W-1:0] first_button;
        logic [ID_W-1:0] second_button;
        logic [EV_W-1:0] reported_event;
        logic            last_of_run;
    } report_t;

    function automatic logic is_release(input logic [EV_W-1:0] ev);
        return ev == EV_CLICK || ev == EV_DOUBLE || ev == EV_REPEAT ||
               ev == EV_SHORT_UP || ev == EV_LONG_UP || ev == EV_HOLD_UP;
    endfunction

    // clicks of any kind are reported as short-up on a combination release
    function automatic logic [EV_W-1:0] release_code(input logic [EV_W-1:0] ev);
        return (ev == EV_CLICK || ev == EV_DOUBLE || ev == EV_REPEAT) ? EV_SHORT_UP : ev;
    endfunction

    function automatic report_t make_report(input logic            combo,
                                           input logic [ID_W-1:0] first,
                                           input logic [ID_W-1:0] second,
                                           input logic [EV_W-1:0] ev,
                                           input logic            last);
        report_t r;
        r.is_combination = combo;
        r.first_button   = first;
        r.second_button  = second;
        r.reported_event = ev;
        r.last_of_run    = last;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/bct_evt_if.sv =====
// input channel: one qualified button event per word
`default_nettype none

interface bct_evt_if;
    import bct_pkg::*;

    logic            valid;
    logic            ready;
    logic [ID_W-1:0] button_id;
    logic [EV_W-1:0] button_event;

    modport source (output valid, output button_id, output button_event, input ready);
    modport sink (input valid, input button_id, input button_event, output ready);
endinterface

`default_nettype wire

// ===== sv/bct_rpt_if.sv =====
// output channel: one single or combination report per word
`default_nettype none

interface bct_rpt_if;
    import bct_pkg::*;

    logic            valid;
    logic            ready;
    logic            is_combination;
    logic [ID_W-1:0] first_button;
    logic [ID_W-1:0] second_button;
    logic [EV_W-1:0] reported_event;
    logic            last_of_run;

    modport source (output valid, output is_combination, output first_button,
                    output second_button, output reported_event, output last_of_run,
                    input ready);
    modport sink (input valid, input is_combination, input first_button,
                  input second_button, input reported_event, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

// ===== sv/bct_cell.sv =====
// one button record cell: holds the record and updates the passing query token
`default_nettype none

module bct_cell #(
    parameter int INDEX = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bct_pkg::rec_wr_t              wr,
    input  bct_pkg::scan_t                tok_in,
    output bct_pkg::scan_t                tok_out,
    output logic [bct_pkg::EV_W-1:0]      record
);
    import bct_pkg::*;

    logic [EV_W-1:0] record_reg;
    logic [EV_W-1:0] record_next;
    scan_t           tok_reg;
    scan_t           tok_next;
    logic            own;
    logic            hit;

    always_comb
    begin
        record_next = record_reg;
        if (wr.en && int'(wr.id) == INDEX)
        begin
            record_next = wr.val;
        end
    end

    always_comb
    begin
        own      = int'(tok_in.self_id) == INDEX;
        hit      = tok_in.valid && !own && record_reg == tok_in.key;
        tok_next = tok_in;
        // lowest index wins: only the first hit along the row is kept
        if (hit && !tok_in.found)
        begin
            tok_next.found     = 1'b1;
            tok_next.found_idx = ID_W'(INDEX);
        end
        if (tok_in.valid && record_reg != NO_RECORD && tok_in.cnt != CNT_SAT)
        begin
            tok_next.cnt = tok_in.cnt + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_reg <= NO_RECORD;
            tok_reg    <= '0;
        end
        else
        begin
            record_reg <= record_next;
            tok_reg    <= tok_next;
        end
    end

    assign tok_out = tok_reg;
    assign record  = record_reg;

endmodule

`default_nettype wire

// ===== sv/bct_out_fifo.sv =====
// two-word report queue between the tracker core and the output channel
`default_nettype none

module bct_out_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bct_pkg::report_t   push_data,
    output logic               full,
    bct_rpt_if.source          rpt
);
    import bct_pkg::*;

    localparam int DEPTH = 2;

    report_t    mem_reg [DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       pop;
    report_t    head;

    assign full = cnt_reg == 2'(DEPTH);
    assign pop  = rpt.valid && rpt.ready;
    assign head = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign rpt.valid          = cnt_reg != 2'd0;
    assign rpt.is_combination = head.is_combination;
    assign rpt.first_button   = head.first_button;
    assign rpt.second_button  = head.second_button;
    assign rpt.reported_event = head.reported_event;
    assign rpt.last_of_run    = head.last_of_run;

endmodule

`default_nettype wire

// ===== sv/button_combination_tracker_core.sv =====
// top level of the button combination tracker: control, cell row and report queue
`default_nettype none

// Takes one button event word at a time and reports it as a single-key or a
// two-key combination event, up to two report words per event. Events that
// need a look at the other buttons (a press-down outside combination mode,
// or any non-press event from a combination member) send a query token down
// a row of BUTTON_COUNT record cells, one cell per cycle; the input stays
// busy until the token has left the row and the report words are in the
// queue. A report word waits in place while the queue is full. Reports go
// through a two-word queue, so a new event can be taken while earlier
// reports still wait at the output. Event codes above 9 are accepted and
// dropped without any report.
module button_combination_tracker_core #(
    parameter int BUTTON_COUNT = bct_pkg::DEF_BUTTON_COUNT
) (
    input  logic       clk,
    input  logic       rst_n,
    bct_evt_if.sink    evt_in,
    bct_rpt_if.source  rpt_out
);
    import bct_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_PUSH0 = 2'd2;
    localparam logic [1:0] S_PUSH1 = 2'd3;

    logic [1:0]      state_reg;
    logic [1:0]      state_next;
    logic            combo_reg;
    logic            combo_next;
    logic [ID_W-1:0] id_reg;
    logic [ID_W-1:0] id_next;
    logic [EV_W-1:0] ev_reg;
    logic [EV_W-1:0] ev_next;
    logic            scan_down_reg;
    logic            scan_down_next;
    report_t         r0_reg;
    report_t         r0_next;
    report_t         r1_reg;
    report_t         r1_next;
    logic [1:0]      nres_reg;
    logic [1:0]      nres_next;
    scan_t           tok_in_reg;
    scan_t           tok_in_next;

    rec_wr_t         wr;
    scan_t           tok [BUTTON_COUNT+1];
    logic [EV_W-1:0] rec_q [BUTTON_COUNT];
    scan_t           tok_last;
    logic [EV_W-1:0] rec_b;
    logic            accept;
    logic [ID_W-1:0] in_id;
    logic [EV_W-1:0] in_ev;
    logic            in_rel;
    logic            ev_rel;
    logic            id_in_range;
    logic            push;
    report_t         push_data;
    logic            fifo_full;

    assign in_id       = evt_in.button_id;
    assign in_ev       = evt_in.button_event;
    assign in_rel      = is_release(in_ev);
    assign ev_rel      = is_release(ev_reg);
    assign id_in_range = int'(id_reg) < BUTTON_COUNT;
    assign evt_in.ready = state_reg == S_IDLE;
    assign accept      = evt_in.valid && evt_in.ready;

    // record of the button named by the incoming word
    always_comb
    begin
        rec_b = NO_RECORD;
        for (int i = 0; i < BUTTON_COUNT; i++)
        begin
            if (int'(in_id) == i)
            begin
                rec_b = rec_q[i];
            end
        end
    end

    assign tok[0] = tok_in_reg;

    for (genvar g = 0; g < BUTTON_COUNT; g++)
    begin : g_cell
        bct_cell #(
            .INDEX(g)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .wr     (wr),
            .tok_in (tok[g]),
            .tok_out(tok[g+1]),
            .record (rec_q[g])
        );
    end

    assign tok_last = tok[BUTTON_COUNT];

    always_comb
    begin
        state_next     = state_reg;
        combo_next     = combo_reg;
        id_next        = id_reg;
        ev_next        = ev_reg;
        scan_down_next = scan_down_reg;
        r0_next        = r0_reg;
        r1_next        = r1_reg;
        nres_next      = nres_reg;
        tok_in_next    = '0;
        wr             = '0;
        push           = 1'b0;
        push_data      = r0_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && in_ev <= EV_MAX)
                begin
                    id_next   = in_id;
                    ev_next   = in_ev;
                    nres_next = 2'd1;
                    if (!combo_reg && in_ev == EV_DOWN)
                    begin
                        // record the press, then count records and look for a pressed partner
                        wr.en   = 1'b1;
                        wr.id   = in_id;
                        wr.val  = EV_DOWN;
                        r0_next = make_report(1'b0, in_id, '0, EV_DOWN, 1'b0);
                        tok_in_next.valid   = 1'b1;
                        tok_in_next.key     = EV_DOWN;
                        tok_in_next.self_id = in_id;
                        scan_down_next      = 1'b1;
                        state_next          = S_SCAN;
                    end
                    else if (!combo_reg)
                    begin
                        wr.en      = in_rel;
                        wr.id      = in_id;
                        wr.val     = NO_RECORD;
                        r0_next    = make_report(1'b0, in_id, '0, in_ev, 1'b1);
                        state_next = S_PUSH0;
                    end
                    else if (in_ev == EV_DOWN || rec_b == NO_RECORD)
                    begin
                        r0_next    = make_report(1'b0, in_id, '0, in_ev, 1'b1);
                        state_next = S_PUSH0;
                    end
                    else
                    begin
                        // member event: a release clears the record right away,
                        // the partner search never looks at the own cell
                        wr.en  = 1'b1;
                        wr.id  = in_id;
                        wr.val = in_rel ? NO_RECORD : in_ev;
                        tok_in_next.valid   = 1'b1;
                        tok_in_next.key     = in_ev;
                        tok_in_next.self_id = in_id;
                        scan_down_next      = 1'b0;
                        state_next          = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (tok_last.valid)
                begin
                    state_next = S_PUSH0;
                    if (scan_down_reg)
                    begin
                        if (tok_last.cnt == CNT_SAT)
                        begin
                            combo_next = 1'b1;
                        end
                        if (tok_last.cnt == CNT_SAT && id_in_range && tok_last.found)
                        begin
                            r1_next   = make_report(1'b1, id_reg, tok_last.found_idx,
                                                    EV_DOWN, 1'b1);
                            nres_next = 2'd2;
                        end
                        else
                        begin
                            r0_next.last_of_run = 1'b1;
                        end
                    end
                    else
                    begin
                        if (ev_rel && tok_last.cnt == 2'd0)
                        begin
                            combo_next = 1'b0;
                        end
                        if (tok_last.found && ev_rel)
                        begin
                            r0_next   = make_report(1'b1, id_reg, tok_last.found_idx,
                                                    ev_reg, 1'b0);
                            r1_next   = make_report(1'b1, id_reg, '0,
                                                    release_code(ev_reg), 1'b1);
                            nres_next = 2'd2;
                        end
                        else if (tok_last.found)
                        begin
                            r0_next = make_report(1'b1, id_reg, tok_last.found_idx,
                                                  ev_reg, 1'b1);
                        end
                        else if (ev_rel)
                        begin
                            r0_next = make_report(1'b1, id_reg, '0,
                                                  release_code(ev_reg), 1'b1);
                        end
                        else
                        begin
                            nres_next  = 2'd0;
                            state_next = S_IDLE;
                        end
                    end
                end
            end

            S_PUSH0:
            begin
                push_data = r0_reg;
                if (!fifo_full)
                begin
                    push       = 1'b1;
                    state_next = (nres_reg == 2'd2) ? S_PUSH1 : S_IDLE;
                end
            end

            S_PUSH1:
            begin
                push_data = r1_reg;
                if (!fifo_full)
                begin
                    push       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            combo_reg     <= 1'b0;
            scan_down_reg <= 1'b0;
            nres_reg      <= 2'd0;
            tok_in_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            combo_reg     <= combo_next;
            scan_down_reg <= scan_down_next;
            nres_reg      <= nres_next;
            tok_in_reg    <= tok_in_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
        ev_reg <= ev_next;
        r0_reg <= r0_next;
        r1_reg <= r1_next;
    end

    bct_out_fifo u_out_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .full     (fifo_full),
        .rpt      (rpt_out)
    );

    // no query token may still be in the row once the next word can be taken
    a_idle_no_token: assert property (@(posedge clk) disable iff (!rst_n)
        evt_in.ready |-> !tok_last.valid)
        else $error("query token still in flight while idle");

    // combination mode only ends at the close of a partner search
    a_combo_exit: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(combo_reg) |-> $past(state_reg == S_SCAN))
        else $error("combination mode left outside a search");

    // a push phase always has one or two words to hand over
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH0 || state_reg == S_PUSH1) |->
            (nres_reg == 2'd1 || nres_reg == 2'd2))
        else $error("push phase with no report words");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// self-checking testbench for the button combination tracker: random traffic, scoreboard, stalls
module tb;
    import bct_pkg::*;

    localparam int BUTTONS    = DEF_BUTTON_COUNT;
    localparam int CYCLE_CAP  = 400000;
    localparam int HOLD_AFTER = 400;
    localparam int HOLD_LEN   = 300;
    localparam int SETTLE     = 40;

    localparam logic [ID_W-1:0] ID_LAST_KEY = ID_W'(BUTTONS - 1);
    localparam logic [ID_W-1:0] ID_TOP      = '1;

    // event codes the package leaves unnamed
    localparam logic [EV_W-1:0] EV_SHORT_START = 4'd4;
    localparam logic [EV_W-1:0] EV_LONG_START  = 4'd6;
    localparam logic [EV_W-1:0] EV_HOLD        = 4'd8;
    localparam logic [EV_W-1:0] EV_FIRST_BAD   = EV_MAX + 4'd1;
    localparam logic [EV_W-1:0] EV_TOP         = '1;

    typedef struct {
        logic [ID_W-1:0] id;
        logic [EV_W-1:0] code;
        bit              drain;
    } btn_word_t;

    logic clk = 1'b0;
    logic rst_n;

    bct_evt_if btn ();
    bct_rpt_if rpt ();

    button_combination_tracker_core #(
        .BUTTON_COUNT (BUTTONS)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .evt_in  (btn),
        .rpt_out (rpt)
    );

    always #5 clk = ~clk;

    btn_word_t pending[$];
    report_t   reports_due[$];

    // predictor state
    logic [EV_W-1:0] held_event [BUTTONS];
    logic            in_combo;

    int errors       = 0;
    int inputs_taken = 0;
    int total_words  = 0;
    int cycles       = 0;

    // ---------------- predictor ----------------

    function automatic logic [EV_W-1:0] record_of(input logic [ID_W-1:0] id);
        return (id < BUTTONS) ? held_event[id] : NO_RECORD;
    endfunction

    function automatic void put_record(input logic [ID_W-1:0] id, input logic [EV_W-1:0] v);
        if (id < BUTTONS)
            held_event[id] = v;
    endfunction

    function automatic int records_held();
        int n;
        n = 0;
        for (int i = 0; i < BUTTONS; i++)
            if (held_event[i] != NO_RECORD)
                n++;
        return n;
    endfunction

    function automatic bit ends_press(input logic [EV_W-1:0] code);
        case (code)
            EV_CLICK, EV_DOUBLE, EV_REPEAT, EV_SHORT_UP, EV_LONG_UP, EV_HOLD_UP: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // lowest-numbered other button holding the same event
    function automatic bit partner_of(input logic [ID_W-1:0] id, input logic [EV_W-1:0] code,
                                      output logic [ID_W-1:0] mate);
        mate = '0;
        for (int j = 0; j < BUTTONS; j++) begin
            if (j != id && held_event[j] == code) begin
                mate = ID_W'(j);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic report_t word_of(input logic combo, input logic [ID_W-1:0] first,
                                        input logic [ID_W-1:0] second,
                                        input logic [EV_W-1:0] code);
        report_t r;
        r.is_combination = combo;
        r.first_button   = first;
        r.second_button  = second;
        r.reported_event = code;
        r.last_of_run    = 1'b0;
        return r;
    endfunction

    function automatic void predict_reports(input logic [ID_W-1:0] id,
                                            input logic [EV_W-1:0] code);
        report_t         words[$];
        logic [ID_W-1:0] mate;
        logic [EV_W-1:0] lift;
        if (code > EV_MAX)
            return;
        if (code == EV_DOWN)
            words.push_back(word_of(1'b0, id, '0, EV_DOWN));
        if (!in_combo) begin
            if (code == EV_DOWN) begin
                put_record(id, EV_DOWN);
                if (records_held() >= 2) begin
                    in_combo = 1'b1;
                    if (record_of(id) != NO_RECORD && partner_of(id, code, mate))
                        words.push_back(word_of(1'b1, id, mate, code));
                end
            end
            else begin
                words.push_back(word_of(1'b0, id, '0, code));
                if (ends_press(code))
                    put_record(id, NO_RECORD);
            end
        end
        else if (code != EV_DOWN) begin
            if (record_of(id) == NO_RECORD) begin
                words.push_back(word_of(1'b0, id, '0, code));
            end
            else begin
                put_record(id, code);
                if (partner_of(id, code, mate))
                    words.push_back(word_of(1'b1, id, mate, code));
                if (ends_press(code)) begin
                    // any click kind comes out as short-up on a combination release
                    case (code)
                        EV_CLICK, EV_DOUBLE, EV_REPEAT: lift = EV_SHORT_UP;
                        default: lift = code;
                    endcase
                    words.push_back(word_of(1'b1, id, '0, lift));
                    put_record(id, NO_RECORD);
                    if (records_held() == 0)
                        in_combo = 1'b0;
                end
            end
        end
        if (words.size() > 0)
            words[words.size() - 1].last_of_run = 1'b1;
        foreach (words[k])
            reports_due.push_back(words[k]);
    endfunction

    // ---------------- stimulus helpers ----------------

    task automatic push_word(input logic [ID_W-1:0] id, input logic [EV_W-1:0] code,
                             input bit drain);
        btn_word_t w;
        w.id    = id;
        w.code  = code;
        w.drain = drain;
        pending.push_back(w);
    endtask

    function automatic logic [EV_W-1:0] hold_like();
        case ($urandom_range(0, 2))
            0: return EV_SHORT_START;
            1: return EV_LONG_START;
            default: return EV_HOLD;
        endcase
    endfunction

    function automatic logic [EV_W-1:0] lift_code();
        case ($urandom_range(0, 5))
            0: return EV_CLICK;
            1: return EV_DOUBLE;
            2: return EV_REPEAT;
            3: return EV_SHORT_UP;
            4: return EV_LONG_UP;
            default: return EV_HOLD_UP;
        endcase
    endfunction

    // two keys pressed together, some shared events, then both let go
    task automatic add_session(input bit drain);
        logic [ID_W-1:0] a, b, who, other;
        logic [EV_W-1:0] shared;
        int steps;
        a = ID_W'($urandom_range(0, BUTTONS - 1));
        do b = ID_W'($urandom_range(0, BUTTONS - 1)); while (b == a);
        push_word(a, EV_DOWN, drain);
        if ($urandom_range(0, 2) == 0)
            push_word(a, hold_like(), 1'b0);
        push_word(b, EV_DOWN, 1'b0);
        steps = $urandom_range(1, 8);
        for (int k = 0; k < steps; k++) begin
            who   = $urandom_range(0, 1) ? a : b;
            other = (who == a) ? b : a;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    shared = hold_like();
                    push_word(who, shared, 1'b0);
                    if ($urandom_range(0, 3) != 0)
                        push_word(other, shared, 1'b0);
                end
                6: push_word(ID_W'($urandom_range(0, 15)), EV_DOWN, 1'b0);
                7: push_word(ID_W'($urandom_range(0, 15)),
                             EV_W'($urandom_range(EV_CLICK, EV_MAX)), 1'b0);
                8: push_word(who, lift_code(), 1'b0);
                default: ;
            endcase
        end
        if ($urandom_range(0, 1)) begin
            push_word(a, lift_code(), 1'b0);
            push_word(b, lift_code(), 1'b0);
        end
        else begin
            push_word(b, lift_code(), 1'b0);
            push_word(a, lift_code(), 1'b0);
        end
    endtask

    // ---------------- sender ----------------

    int burst_left = 0;
    int gap_left   = 0;
    btn_word_t next_word;

    always @(posedge clk) begin
        if (!rst_n) begin
            btn.valid <= 1'b0;
        end
        else if (!btn.valid || btn.ready) begin
            if (gap_left > 0) begin
                gap_left  <= gap_left - 1;
                btn.valid <= 1'b0;
            end
            else if (pending.size() == 0) begin
                btn.valid <= 1'b0;
            end
            else if (pending[0].drain && (btn.valid || reports_due.size() != 0)) begin
                // hold back until every report so far has come out
                btn.valid <= 1'b0;
            end
            else begin
                next_word        = pending.pop_front();
                btn.valid        <= 1'b1;
                btn.button_id    <= next_word.id;
                btn.button_event <= next_word.code;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // ---------------- receiver ----------------

    logic [15:0] rx_cycle  = '0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    always @(posedge clk) begin
        if (!rst_n) begin
            rpt.ready <= 1'b0;
        end
        else begin
            rx_cycle <= rx_cycle + 16'd1;
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                rpt.ready <= 1'b0;
            end
            else if (!hold_done && inputs_taken >= HOLD_AFTER) begin
                // long hold-off so the report queue fills and the input backs up
                hold_done <= 1'b1;
                hold_left <= HOLD_LEN;
                rpt.ready <= 1'b0;
            end
            else begin
                case (rx_cycle[8:6])
                    3'd0, 3'd1: rpt.ready <= 1'b1;
                    3'd2: rpt.ready <= ($urandom_range(0, 3) != 0);
                    3'd3: rpt.ready <= $urandom_range(0, 1);
                    3'd4: rpt.ready <= ($urandom_range(0, 4) == 0);
                    3'd5: rpt.ready <= (rx_cycle[1:0] != 2'b11);
                    3'd6: rpt.ready <= rx_cycle[2];
                    default: rpt.ready <= 1'b1;
                endcase
            end
        end
    end

    // ---------------- scoreboard ----------------

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    report_t want;

    always @(posedge clk) begin
        if (rst_n) begin
            if (btn.valid && btn.ready) begin
                predict_reports(btn.button_id, btn.button_event);
                inputs_taken <= inputs_taken + 1;
            end
            if (rpt.valid && rpt.ready) begin
                if (reports_due.size() == 0) begin
                    $error("report word with none expected: first_button %0d, event %0d",
                           rpt.first_button, rpt.reported_event);
                    errors++;
                end
                else begin
                    want = reports_due.pop_front();
                    check_field("is_combination", want.is_combination, rpt.is_combination);
                    check_field("first_button", want.first_button, rpt.first_button);
                    check_field("second_button", want.second_button, rpt.second_button);
                    check_field("reported_event", want.reported_event, rpt.reported_event);
                    check_field("last_of_run", want.last_of_run, rpt.last_of_run);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_CAP) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        int counted;
        int next_drain;
        logic [EV_W-1:0] code;

        rst_n            = 1'b0;
        btn.valid        = 1'b0;
        btn.button_id    = '0;
        btn.button_event = EV_DOWN;
        rpt.ready        = 1'b0;
        in_combo         = 1'b0;
        for (int i = 0; i < BUTTONS; i++)
            held_event[i] = NO_RECORD;

        // directed: ignored codes, keys past the table, combo entry and exit
        push_word('0, EV_FIRST_BAD, 1'b0);
        push_word(ID_TOP, EV_TOP, 1'b0);
        push_word(ID_TOP, EV_DOWN, 1'b0);
        push_word(ID_W'(BUTTONS), EV_HOLD, 1'b0);
        push_word(4'd4, EV_DOWN, 1'b0);
        push_word(4'd4, EV_DOWN, 1'b0);
        push_word(4'd4, EV_SHORT_START, 1'b0);
        push_word(4'd6, EV_DOWN, 1'b0);
        push_word(4'd9, EV_DOWN, 1'b0);
        push_word(4'd14, EV_LONG_START, 1'b0);
        push_word(4'd6, EV_SHORT_START, 1'b0);
        push_word(4'd4, EV_SHORT_START, 1'b0);
        push_word(4'd6, EV_REPEAT, 1'b0);
        push_word(4'd4, EV_LONG_UP, 1'b0);
        push_word('0, EV_DOWN, 1'b0);
        push_word(ID_LAST_KEY, EV_DOWN, 1'b0);
        push_word('0, EV_HOLD, 1'b0);
        push_word(ID_LAST_KEY, EV_HOLD, 1'b0);
        push_word(ID_LAST_KEY, EV_CLICK, 1'b0);
        push_word('0, EV_DOUBLE, 1'b0);
        push_word(4'd3, EV_SHORT_UP, 1'b0);
        push_word(4'd1, EV_DOWN, 1'b0);
        push_word(4'd1, EV_HOLD_UP, 1'b0);
        push_word(4'd2, EV_DOWN, 1'b0);
        push_word(4'd11, EV_DOWN, 1'b0);
        push_word(4'd2, EV_HOLD_UP, 1'b0);
        push_word(4'd11, EV_SHORT_UP, 1'b1);

        // random: mostly two-key sessions, some loose noise
        counted    = 0;
        next_drain = 250;
        while (counted < 1400) begin
            if ($urandom_range(0, 9) < 7) begin
                add_session(counted >= next_drain);
                if (counted >= next_drain)
                    next_drain += 250;
            end
            else begin
                code = EV_W'($urandom_range(0, 15));
                push_word(ID_W'($urandom_range(0, 15)), code, 1'b0);
            end
            counted = 0;
            foreach (pending[k])
                if (pending[k].code <= EV_MAX)
                    counted++;
        end
        total_words = pending.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (inputs_taken != total_words || reports_due.size() != 0);
        repeat (SETTLE) @(posedge clk);

        if (errors == 0 && reports_due.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
